### sv/dcfr_pkg.sv
// Package for the display command frame receiver.
// Holds shared constants, level codes and the framer status struct.
// No dependencies.
package dcfr_pkg;

    localparam int unsigned FRAME_LEN_DEF = 7;

    localparam logic [7:0] START_BYTE_RST = 8'h59;

    // Request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Control byte fields
    localparam logic [7:0] LEVEL_MASK  = 8'hDE;
    localparam logic [7:0] LIGHTS_BIT  = 8'h01;
    localparam logic [7:0] WALK_BIT    = 8'h20;

    // Masked level codes
    localparam logic [7:0] CODE_OFF   = 8'h10;
    localparam logic [7:0] CODE_LOW   = 8'h80;
    localparam logic [7:0] CODE_ECO   = 8'h40;
    localparam logic [7:0] CODE_TOUR  = 8'h02;
    localparam logic [7:0] CODE_SPORT = 8'h04;
    localparam logic [7:0] CODE_TURBO = 8'h08;

    // Assist levels
    localparam logic [2:0] LVL_OFF   = 3'd0;
    localparam logic [2:0] LVL_ECO   = 3'd1;
    localparam logic [2:0] LVL_TOUR  = 3'd2;
    localparam logic [2:0] LVL_SPORT = 3'd3;
    localparam logic [2:0] LVL_TURBO = 3'd4;

    localparam logic [7:0] SILENCE_MAX = 8'hFF;

    // Framer result for one accepted item
    typedef struct packed {
        logic       done;     // item completed a frame
        logic       ok;       // checksum matched
        logic       good;     // accepted item closed a good frame
        logic [7:0] control;  // control byte of the current frame
    } frm_status_t;

endpackage

### sv/dcfr_if.sv
// Handshake channels of the display command frame receiver.
// Request channel carries bytes and ticks; response channel carries status.
// No dependencies.
interface dcfr_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface dcfr_rsp_if;
    logic       valid;
    logic       ready;
    logic       frame_done;
    logic       frame_ok;
    logic       lights_request;
    logic       walk_request;
    logic [2:0] assist_level;
    logic       assist_low;
    logic [7:0] silence_count;

    modport source (output valid, output frame_done, output frame_ok,
                    output lights_request, output walk_request, output assist_level,
                    output assist_low, output silence_count, input ready);
    modport sink   (input valid, input frame_done, input frame_ok,
                    input lights_request, input walk_request, input assist_level,
                    input assist_low, input silence_count, output ready);
endinterface

### sv/dcfr_framer.sv
// Frame hunter and gatherer: start byte search, byte count, checksum.
// Depends on dcfr_pkg.
module dcfr_framer
    import dcfr_pkg::*;
#(
    parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        accept,
    input  logic        req_type,
    input  logic [7:0]  rx_byte,
    output frm_status_t status
);

    localparam int unsigned CntW = $clog2(FRAME_LEN);
    localparam logic [CntW-1:0] LastIdx = CntW'(FRAME_LEN - 1);

    logic [7:0]      start_byte_reg;
    logic            collecting_reg, collecting_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      control_reg, control_next;
    logic            done_reg, done_next;
    logic            ok_reg, ok_next;

    always_comb
    begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        control_next    = control_reg;
        done_next       = 1'b0;
        ok_next         = 1'b0;
        if (req_type == REQ_BYTE)
        begin
            if (!collecting_reg)
            begin
                if (rx_byte == start_byte_reg)
                begin
                    sum_next        = rx_byte;
                    count_next      = CntW'(1);
                    collecting_next = 1'b1;
                end
                else
                begin
                    count_next = '0;
                end
            end
            else if (count_reg >= LastIdx)
            begin
                // last byte holds the checksum
                done_next       = 1'b1;
                ok_next         = (sum_reg == rx_byte);
                collecting_next = 1'b0;
                count_next      = '0;
            end
            else
            begin
                if (count_reg == CntW'(1))
                begin
                    control_next = rx_byte;
                end
                sum_next   = sum_reg + rx_byte;
                count_next = count_reg + CntW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            control_reg    <= '0;
            done_reg       <= 1'b0;
            ok_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_byte_reg <= cfg_wdata;
            end
            if (accept)
            begin
                collecting_reg <= collecting_next;
                count_reg      <= count_next;
                sum_reg        <= sum_next;
                control_reg    <= control_next;
                done_reg       <= done_next;
                ok_reg         <= ok_next;
            end
        end
    end

    assign status.done    = done_reg;
    assign status.ok      = ok_reg;
    assign status.good    = accept && done_next && ok_next;
    assign status.control = control_reg;

endmodule

### sv/dcfr_decoder.sv
// Control byte decoder and silence counter; holds the reported status.
// Depends on dcfr_pkg.
module dcfr_decoder
    import dcfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        req_type,
    input  frm_status_t status,
    output logic        lights_request,
    output logic        walk_request,
    output logic [2:0]  assist_level,
    output logic        assist_low,
    output logic [7:0]  silence_count
);

    logic       lights_reg, lights_next;
    logic       walk_reg, walk_next;
    logic [2:0] level_reg, level_next;
    logic       low_reg, low_next;
    logic [7:0] silence_reg, silence_next;
    logic [7:0] masked;

    assign masked = status.control & LEVEL_MASK;

    always_comb
    begin
        lights_next  = lights_reg;
        walk_next    = walk_reg;
        level_next   = level_reg;
        low_next     = low_reg;
        silence_next = silence_reg;
        if (req_type == REQ_TICK)
        begin
            if (silence_reg != SILENCE_MAX)
            begin
                silence_next = silence_reg + 8'd1;
            end
        end
        else if (status.good)
        begin
            silence_next = '0;
            lights_next  = |(status.control & LIGHTS_BIT);
            walk_next    = |(status.control & WALK_BIT);
            low_next     = 1'b0;
            // unmatched mask: keep the level
            case (masked)
                CODE_OFF:   level_next = LVL_OFF;
                CODE_LOW:
                begin
                    level_next = LVL_ECO;
                    low_next   = 1'b1;
                end
                CODE_ECO:   level_next = LVL_ECO;
                CODE_TOUR:  level_next = LVL_TOUR;
                CODE_SPORT: level_next = LVL_SPORT;
                CODE_TURBO: level_next = LVL_TURBO;
                default:    level_next = level_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lights_reg  <= 1'b0;
            walk_reg    <= 1'b0;
            level_reg   <= LVL_OFF;
            low_reg     <= 1'b0;
            silence_reg <= '0;
        end
        else if (accept)
        begin
            lights_reg  <= lights_next;
            walk_reg    <= walk_next;
            level_reg   <= level_next;
            low_reg     <= low_next;
            silence_reg <= silence_next;
        end
    end

    assign lights_request = lights_reg;
    assign walk_request   = walk_reg;
    assign assist_level   = level_reg;
    assign assist_low     = low_reg;
    assign silence_count  = silence_reg;

endmodule

### sv/display_command_frame_receiver.sv
// State and result registers update together on accept and drive rsp in the next cycle.
// Throughput: one item per cycle while req.ready is high.
// req.ready stays high while the result register is empty or being taken.
// Reset (rst_n low, asynchronous) returns to hunting, clears status and silence count,
// and loads start byte 0x59.
module display_command_frame_receiver
    import dcfr_pkg::*;
#(
    parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    dcfr_req_if.sink    req,
    dcfr_rsp_if.source  rsp
);

    logic        accept;
    logic        valid_reg, valid_next;
    frm_status_t status;

    assign req.ready = !valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    dcfr_framer #(
        .FRAME_LEN (FRAME_LEN)
    ) u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .req_type  (req.req_type),
        .rx_byte   (req.rx_byte),
        .status    (status)
    );

    dcfr_decoder u_decoder (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req_type       (req.req_type),
        .status         (status),
        .lights_request (rsp.lights_request),
        .walk_request   (rsp.walk_request),
        .assist_level   (rsp.assist_level),
        .assist_low     (rsp.assist_low),
        .silence_count  (rsp.silence_count)
    );

    assign rsp.valid      = valid_reg;
    assign rsp.frame_done = status.done;
    assign rsp.frame_ok   = status.ok;

`ifndef SYNTHESIS
    // a good frame always clears the silence count it reports
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.frame_ok |-> rsp.frame_done && rsp.silence_count == 8'd0)
        else $error("good frame with nonzero silence count");

    // a tick advances the silence count, saturating
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_TICK |=>
            (rsp.silence_count == SILENCE_MAX && $past(rsp.silence_count) == SILENCE_MAX) ||
            (rsp.silence_count == $past(rsp.silence_count) + 8'd1))
        else $error("tick did not advance silence count");

    // a tick never completes a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_TICK |=> !rsp.frame_done && !rsp.frame_ok)
        else $error("tick reported a frame");

    // status only moves when an item is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(rsp.silence_count) && $stable(rsp.assist_level))
        else $error("status changed without an item");
`endif

endmodule

### tb/sv/testbench.sv
// Testbench for display_command_frame_receiver: frames, ticks and noise go in on req.
// A scoreboard class predicts each response; rsp items are checked field by field.
// Depends on dcfr_pkg, dcfr_if and the receiver RTL.
`timescale 1ns / 1ps

module testbench;
    import dcfr_pkg::*;

    typedef struct packed {
        logic       done;
        logic       ok;
        logic       lights;
        logic       walk;
        logic [2:0] level;
        logic       low;
        logic [7:0] silence;
    } rx_status_t;

    class frame_scoreboard;
        logic [7:0] start_val;
        bit         collecting;
        bit [3:0]   count;
        bit [7:0]   sum;
        bit [7:0]   ctrl;
        bit [2:0]   level;
        bit         lights;
        bit         walk;
        bit         low;
        bit [7:0]   silence;
        rx_status_t status_q[$];
        int         errors;

        function new();
            start_val  = START_BYTE_RST;
            collecting = 0;
            count      = 0;
            sum        = 0;
            ctrl       = 0;
            level      = LVL_OFF;
            lights     = 0;
            walk       = 0;
            low        = 0;
            silence    = 0;
            errors     = 0;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // Advance the frame state on one accepted item and queue its status.
        function void note_request(logic kind, logic [7:0] b);
            rx_status_t s;
            bit         done;
            bit         ok;
            done = 0;
            ok   = 0;
            if (kind == REQ_TICK)
            begin
                if (silence != SILENCE_MAX)
                    silence = silence + 8'd1;
            end
            else if (!collecting)
            begin
                if (b == start_val)
                begin
                    sum        = b;
                    count      = 1;
                    collecting = 1;
                end
                else
                    count = 0;
            end
            else if (count >= FRAME_LEN_DEF - 1)
            begin
                done       = 1;
                ok         = (sum == b);
                collecting = 0;
                count      = 0;
                if (ok)
                begin
                    silence = 0;
                    lights  = (ctrl & LIGHTS_BIT) != 0;
                    walk    = (ctrl & WALK_BIT) != 0;
                    low     = 0;
                    // an unmatched mask keeps the level
                    case (ctrl & LEVEL_MASK)
                        CODE_OFF:   level = LVL_OFF;
                        CODE_LOW:
                        begin
                            level = LVL_ECO;
                            low   = 1;
                        end
                        CODE_ECO:   level = LVL_ECO;
                        CODE_TOUR:  level = LVL_TOUR;
                        CODE_SPORT: level = LVL_SPORT;
                        CODE_TURBO: level = LVL_TURBO;
                        default: ;
                    endcase
                end
            end
            else
            begin
                if (count == 1)
                    ctrl = b;
                sum   = sum + b;
                count = count + 4'd1;
            end
            s.done    = done;
            s.ok      = ok;
            s.lights  = lights;
            s.walk    = walk;
            s.level   = level;
            s.low     = low;
            s.silence = silence;
            status_q.push_back(s);
        endfunction

        function void match_field(string name, logic [7:0] want, logic [7:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(rx_status_t got);
            rx_status_t want;
            if (status_q.size() == 0)
            begin
                $error("response with no item outstanding: %0h", got);
                errors++;
                return;
            end
            want = status_q.pop_front();
            match_field("frame_done", 8'(want.done), 8'(got.done));
            match_field("frame_ok", 8'(want.ok), 8'(got.ok));
            match_field("lights_request", 8'(want.lights), 8'(got.lights));
            match_field("walk_request", 8'(want.walk), 8'(got.walk));
            match_field("assist_level", 8'(want.level), 8'(got.level));
            match_field("assist_low", 8'(want.low), 8'(got.low));
            match_field("silence_count", want.silence, got.silence);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    dcfr_req_if req_ch();
    dcfr_rsp_if rsp_ch();

    display_command_frame_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    frame_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int items_sent;

    logic [7:0] level_codes [6] = '{CODE_OFF, CODE_LOW, CODE_ECO,
                                    CODE_TOUR, CODE_SPORT, CODE_TURBO};

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result({rsp_ch.frame_done, rsp_ch.frame_ok, rsp_ch.lights_request,
                                 rsp_ch.walk_request, rsp_ch.assist_level,
                                 rsp_ch.assist_low, rsp_ch.silence_count});
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.req_type, req_ch.rx_byte);
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.rx_byte  <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    // Send the first len bytes of a frame; a full frame's last byte is the checksum.
    task automatic send_frame(input logic [7:0] ctrl, input bit corrupt,
                              input int tick_pct, input int len);
        logic [7:0] sum;
        logic [7:0] b;
        sum = sb.start_val;
        send_item(REQ_BYTE, sb.start_val);
        for (int i = 1; i < len; i++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_item(REQ_TICK, 8'($urandom));
            if (i == 1)
                b = ctrl;
            else if (i == FRAME_LEN_DEF - 1)
                b = corrupt ? sum + 8'($urandom_range(255, 1)) : sum;
            else if ($urandom_range(99) < 15)
                b = sb.start_val;
            else
                b = 8'($urandom);
            sum = sum + b;
            send_item(REQ_BYTE, b);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.start_val = v;
    endtask

    task automatic run_phase(input int target);
        int         first;
        int         roll;
        logic [7:0] ctrl;
        logic [7:0] b;
        first = items_sent;
        while (items_sent - first < target)
        begin
            roll = $urandom_range(99);
            if (roll < 75)
            begin
                if ($urandom_range(99) < 70)
                    ctrl = level_codes[$urandom_range(5)] | (8'($urandom) & ~LEVEL_MASK);
                else
                    ctrl = 8'($urandom);
                send_frame(ctrl, $urandom_range(99) < 12, 10, FRAME_LEN_DEF);
            end
            else if (roll < 85)
            begin
                b = 8'($urandom);
                // keep most noise off the start byte so frames stay aligned
                if (b == sb.start_val && $urandom_range(1))
                    b = ~b;
                send_item(REQ_BYTE, b);
            end
            else if (roll < 93)
                send_item(REQ_TICK, 8'($urandom));
            else
                send_frame(8'($urandom), 0, 10, $urandom_range(FRAME_LEN_DEF - 1, 1));
        end
    endtask

    initial
    begin
        sb         = new();
        idle_pct   = 0;
        stall_pct  = 0;
        items_sent = 0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= 8'h00;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_BYTE;
        req_ch.rx_byte   <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick, hunting noise, good frame with random ticks inside,
        // bad checksum with the start value as data, unmatched level mask
        send_item(REQ_TICK, 8'hFF);
        send_item(REQ_BYTE, 8'h00);
        send_item(REQ_BYTE, 8'hFF);
        send_frame(8'hA1, 0, 30, FRAME_LEN_DEF);
        send_frame(START_BYTE_RST, 1, 0, FRAME_LEN_DEF);
        send_frame(8'hFF, 0, 0, FRAME_LEN_DEF);
        drain();

        write_start(8'h00);
        // hold off good frames long enough to saturate the silence count
        repeat (270) send_item(REQ_TICK, 8'($urandom));
        run_phase(220);
        drain();

        idle_pct = 64;
        write_start(8'hFF);
        run_phase(480);
        drain();

        idle_pct  = 0;
        stall_pct = 64;
        write_start(8'($urandom));
        run_phase(480);
        drain();

        idle_pct  = 17;
        stall_pct = 17;
        write_start(START_BYTE_RST);
        run_phase(480);
        drain();

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
